@@ sv/arla_pkg.sv @@
// ---------------------------------------------------------------------------
// arla_pkg
// Shared constants for the adaptive run-length averager: field widths,
// register map, reset values, command codes and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arla_pkg;

  // Default sizes handed to the top level
  localparam int HIST_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int HCOUNT_W  = 7;
  localparam int TARGET_W  = 48;
  localparam int INITVAL_W = 32;
  localparam int ELAPSED_W = 48;
  localparam int RUNLEN_W  = 32;

  // Target multiply is done in 16-bit slices
  localparam int TCHUNK_W = 16;
  localparam int TCHUNKS  = TARGET_W / TCHUNK_W;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam logic [1:0] REG_HIST_COUNT   = 2'd0;
  localparam logic [1:0] REG_TARGET       = 2'd1;
  localparam logic [1:0] REG_INITIAL      = 2'd2;

  // Register reset values
  localparam logic [HCOUNT_W-1:0]  HCOUNT_RST  = 7'd8;
  localparam logic [TARGET_W-1:0]  TARGET_RST  = 48'd1000000;
  localparam logic [INITVAL_W-1:0] INITVAL_RST = 32'd1;

  // Commands
  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

endpackage : arla_pkg

`default_nettype wire

@@ sv/adaptive_run_length_averager_core.sv @@
// ---------------------------------------------------------------------------
// adaptive_run_length_averager_core
// Proportional run-length correction averaged over a history ring kept in a
// synchronous RAM; one command in, one run length out.
// ---------------------------------------------------------------------------
// Sequence: init writes one RAM entry per active history entry, then forms the sum;
//   update multiplies in TCHUNKS slices, divides by the elapsed count, replaces one
//   ring entry and divides the ring sum by the count, both on the bit-serial divider;
//   a zero elapsed count skips the multiply and the first division.
// Throughput: one command at a time; the next is taken once the result is in
//   the output register.
// Reset: synchronous; after reset a clearing pass loads every ring entry
//   with 1 before the first command is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_run_length_averager_core #(
  parameter int HIST_DEPTH = arla_pkg::HIST_DEPTH_DEF,
  parameter int VALUE_BITS = arla_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             cmd,
  input  wire logic [arla_pkg::ELAPSED_W-1:0]   elapsed_cycles,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [arla_pkg::RUNLEN_W-1:0]    run_length,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [arla_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [arla_pkg::PDATA_W-1:0]     pwdata,
  output logic      [arla_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int IDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int P_W    = VALUE_BITS + arla_pkg::TARGET_W;
  localparam int PP_W   = VALUE_BITS + arla_pkg::TCHUNK_W;
  localparam int PAD_W  = P_W - SUM_W;
  localparam int D_W    = arla_pkg::ELAPSED_W;
  localparam int STEP_W = $clog2(P_W + 1);
  localparam int K_W    = $clog2(arla_pkg::TCHUNKS);
  localparam int RST_N  = (HIST_DEPTH < 8) ? HIST_DEPTH : 8;

  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  // Sequencer states
  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_FILL      = 4'd2;
  localparam logic [3:0] S_INIT_SUM  = 4'd3;
  localparam logic [3:0] S_MUL       = 4'd4;
  localparam logic [3:0] S_ACC       = 4'd5;
  localparam logic [3:0] S_DIV1_GO   = 4'd6;
  localparam logic [3:0] S_DIV1_WAIT = 4'd7;
  localparam logic [3:0] S_RD        = 4'd8;
  localparam logic [3:0] S_RMW       = 4'd9;
  localparam logic [3:0] S_DIV2_GO   = 4'd10;
  localparam logic [3:0] S_DIV2_WAIT = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state;

  // Configuration registers
  logic [arla_pkg::HCOUNT_W-1:0]  history_count;
  logic [arla_pkg::TARGET_W-1:0]  target_cycles;
  logic [arla_pkg::INITVAL_W-1:0] initial_value;

  // Working state
  logic [CNT_W-1:0]      active_count;
  logic [SUM_W-1:0]      history_sum;
  logic [IDX_W-1:0]      write_index;
  logic [VALUE_BITS-1:0] current_value;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] fill_value;
  logic [IDX_W-1:0]      ptr;
  logic [D_W-1:0]        elapsed;
  logic [P_W-1:0]        prod;
  logic [PP_W-1:0]       pp;
  logic [K_W-1:0]        mul_k;

  // RAM and divider hookup
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  div_start;
  logic [STEP_W-1:0]     div_steps;
  logic [P_W-1:0]        div_dividend;
  logic [D_W-1:0]        div_divisor;
  logic                  div_done;
  logic [P_W-1:0]        div_quo;
  logic [VALUE_BITS-1:0] quo_sat;

  // Init operands from configuration
  logic [31:0]           hc_wide;
  logic [CNT_W-1:0]      init_n;
  logic [VALUE_BITS-1:0] init_v_raw;
  logic [VALUE_BITS-1:0] init_v;

  logic cfg_wr;
  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  // Configuration port: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_count <= arla_pkg::HCOUNT_RST;
      target_cycles <= arla_pkg::TARGET_RST;
      initial_value <= arla_pkg::INITVAL_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        arla_pkg::REG_HIST_COUNT: history_count <= pwdata[arla_pkg::HCOUNT_W-1:0];
        arla_pkg::REG_TARGET:     target_cycles <= pwdata[arla_pkg::TARGET_W-1:0];
        arla_pkg::REG_INITIAL:    initial_value <= pwdata[arla_pkg::INITVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:3])
      arla_pkg::REG_HIST_COUNT: prdata = arla_pkg::PDATA_W'(history_count);
      arla_pkg::REG_TARGET:     prdata = arla_pkg::PDATA_W'(target_cycles);
      arla_pkg::REG_INITIAL:    prdata = arla_pkg::PDATA_W'(initial_value);
      default:                  prdata = '0;
    endcase
  end

  // Clamp the count to 1..HIST_DEPTH and the initial value to at least 1
  always_comb begin
    hc_wide = 32'(history_count);
    if (hc_wide == 32'd0) begin
      init_n = CNT_W'(1);
    end else if (hc_wide > 32'(HIST_DEPTH)) begin
      init_n = CNT_W'(HIST_DEPTH);
    end else begin
      init_n = CNT_W'(hc_wide);
    end
    init_v_raw = VALUE_BITS'({32'd0, initial_value});
    init_v     = (init_v_raw == '0) ? VALUE_BITS'(1) : init_v_raw;
  end

  // Saturate a quotient to the value range, never below 1
  always_comb begin
    if (|div_quo[P_W-1:VALUE_BITS]) begin
      quo_sat = VMAX;
    end else if (div_quo[VALUE_BITS-1:0] == '0) begin
      quo_sat = VALUE_BITS'(1);
    end else begin
      quo_sat = div_quo[VALUE_BITS-1:0];
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_index;
    ram_wdata = cand;
    ram_re    = (state == S_RD);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = VALUE_BITS'(1);
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = fill_value;
      end
      S_RMW: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Divider launch: product over elapsed, then sum over count
  always_comb begin
    div_start    = (state == S_DIV1_GO) || (state == S_DIV2_GO);
    if (state == S_DIV1_GO) begin
      div_steps    = STEP_W'(P_W);
      div_dividend = prod;
      div_divisor  = elapsed;
    end else begin
      div_steps    = STEP_W'(SUM_W);
      div_dividend = {history_sum, {PAD_W{1'b0}}};
      div_divisor  = D_W'(active_count);
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ptr           <= '0;
      active_count  <= CNT_W'(RST_N);
      history_sum   <= SUM_W'(RST_N);
      write_index   <= '0;
      current_value <= VALUE_BITS'(1);
      mul_k         <= '0;
      out_valid     <= 1'b0;
    end else begin
      // raise the result once the output register is free, drop it on transfer
      if (state == S_DONE && (!out_valid || out_xfer)) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        // sweep the ring to its reset value
        S_CLEAR: begin
          if (ptr == IDX_W'(HIST_DEPTH - 1)) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (cmd == arla_pkg::CMD_INIT) begin
              active_count <= init_n;
              ptr          <= '0;
              state        <= S_FILL;
            end else if (elapsed_cycles == '0) begin
              state <= S_RD;
            end else begin
              mul_k <= K_W'(arla_pkg::TCHUNKS - 1);
              state <= S_MUL;
            end
          end
        end
        // one ring entry per cycle
        S_FILL: begin
          if (ptr == IDX_W'(active_count - 1'b1)) begin
            ptr   <= '0;
            state <= S_INIT_SUM;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_INIT_SUM: begin
          history_sum   <= SUM_W'(fill_value) * SUM_W'(active_count);
          write_index   <= '0;
          current_value <= fill_value;
          state         <= S_DONE;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          mul_k <= mul_k - 1'b1;
          state <= (mul_k == '0) ? S_DIV1_GO : S_MUL;
        end
        S_DIV1_GO: begin
          state <= S_DIV1_WAIT;
        end
        S_DIV1_WAIT: begin
          if (div_done) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RMW;
        end
        // replace the oldest entry and step the index downward
        S_RMW: begin
          history_sum <= history_sum - SUM_W'(ram_rdata) + SUM_W'(cand);
          write_index <= (write_index == '0) ? IDX_W'(active_count - 1'b1)
                                             : write_index - 1'b1;
          state       <= S_DIV2_GO;
        end
        S_DIV2_GO: begin
          state <= S_DIV2_WAIT;
        end
        S_DIV2_WAIT: begin
          if (div_done) begin
            current_value <= quo_sat;
            state         <= S_DONE;
          end
        end
        // hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || out_xfer) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      fill_value <= init_v;
      elapsed    <= elapsed_cycles;
      prod       <= '0;
      cand       <= VMAX;
    end
    if (state == S_MUL) begin
      pp <= current_value * target_cycles[mul_k*arla_pkg::TCHUNK_W +: arla_pkg::TCHUNK_W];
    end
    if (state == S_ACC) begin
      prod <= (prod << arla_pkg::TCHUNK_W) + P_W'(pp);
    end
    if (state == S_DIV1_WAIT && div_done) begin
      cand <= quo_sat;
    end
    if (state == S_DONE && (!out_valid || out_xfer)) begin
      run_length <= arla_pkg::RUNLEN_W'(current_value);
    end
  end

  arla_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (write_index),
    .rdata (ram_rdata)
  );

  arla_div #(
    .N_W (P_W),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule : adaptive_run_length_averager_core

`default_nettype wire

@@ sv/arla_ram.sv @@
// ---------------------------------------------------------------------------
// arla_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : arla_ram

`default_nettype wire

@@ sv/arla_div.sv @@
// ---------------------------------------------------------------------------
// arla_div
// Iterative restoring divider, one quotient bit per cycle. The dividend is
// taken MSB first; the step count sets how many of its top bits are used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arla_div #(
  parameter int N_W = 80,
  parameter int D_W = 48,
  localparam int STEP_W = $clog2(N_W + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] steps,
  input  wire logic [N_W-1:0]    dividend,
  input  wire logic [D_W-1:0]    divisor,
  output logic                   done,
  output logic      [N_W-1:0]    quotient
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [N_W-1:0]    num;
  logic [D_W-1:0]    den;
  logic [D_W-1:0]    rem;
  logic [D_W:0]      rem_sh;
  logic [D_W:0]      rem_sub;
  logic              ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem, num[N_W-1]};
    ge      = (rem_sh >= {1'b0, den});
    rem_sub = rem_sh - {1'b0, den};
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= num << 1;
      rem      <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
      quotient <= {quotient[N_W-2:0], ge};
    end
  end

endmodule : arla_div

`default_nettype wire
